// ----- design/cls_pkg.sv -----
// Shared types, phase codes and reset constants for the character LCD bus sequencer.
// Used by cls_step and char_lcd_bus_sequencer; depends on nothing else.
package cls_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CMD    = 2'd1;
    localparam logic [1:0] OP_CHAR   = 2'd2;
    localparam logic [1:0] OP_CURSOR = 2'd3;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_POLL    = 3'd1;
    localparam logic [2:0] PH_RELEASE = 3'd2;
    localparam logic [2:0] PH_PRE     = 3'd3;
    localparam logic [2:0] PH_WR_E    = 3'd4;
    localparam logic [2:0] PH_WR_DATA = 3'd5;
    localparam logic [2:0] PH_WR_LOW  = 3'd6;
    localparam logic [2:0] PH_POST    = 3'd7;

    localparam logic [1:0] REG_QUARTER_TICKS = 2'd0;
    localparam logic [1:0] REG_CMD_PRE_US    = 2'd1;
    localparam logic [1:0] REG_CMD_POST_US   = 2'd2;
    localparam logic [1:0] REG_DATA_POST_US  = 2'd3;

    localparam logic [7:0]  RST_QUARTER_TICKS = 8'd42;
    localparam logic [7:0]  RST_CMD_PRE_US    = 8'd8;
    localparam logic [11:0] RST_CMD_POST_US   = 12'd1000;
    localparam logic [7:0]  RST_DATA_POST_US  = 8'd39;

    localparam logic [7:0] CURSOR_CMD  = 8'h80;
    localparam logic [7:0] ROW2_OFFSET = 8'h40;
    localparam logic [1:0] FIRST_ROW   = 2'd1;

    localparam int CFG_DATA_W = 12;

    typedef struct packed {
        logic [7:0]  quarter_ticks;
        logic [7:0]  cmd_pre_us;
        logic [11:0] cmd_post_us;
        logic [7:0]  data_post_us;
    } cls_cfg_t;

    typedef struct packed {
        logic       e;
        logic       rs;
        logic       rw;
        logic       sel;
        logic [7:0] data;
        logic       drive;
    } cls_pins_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  tick_count;
        logic [13:0] units_left;
        logic [7:0]  latched;
        logic [1:0]  kind;
        cls_pins_t   pins;
        logic [7:0]  status;
    } cls_state_t;

endpackage

// ----- design/cls_if.sv -----
// Valid/ready channel interfaces for the request beats and the pin-level result beats.
// Stand-alone; no package dependency.
interface cls_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] value;
    logic [6:0] column;
    logic [1:0] row;
    logic [7:0] bus_in;

    modport source (output valid, opcode, value, column, row, bus_in, input ready);
    modport sink (input valid, opcode, value, column, row, bus_in, output ready);
endinterface

interface cls_rsp_if;
    logic       valid;
    logic       ready;
    logic       enable_pin;
    logic       reg_select_pin;
    logic       read_write_pin;
    logic       select_pin;
    logic [7:0] data_out;
    logic       drive_data;
    logic       busy_res;
    logic [7:0] status_byte;

    modport source (output valid, enable_pin, reg_select_pin, read_write_pin, select_pin,
                    data_out, drive_data, busy_res, status_byte, input ready);
    modport sink (input valid, enable_pin, reg_select_pin, read_write_pin, select_pin,
                  data_out, drive_data, busy_res, status_byte, output ready);
endinterface

// ----- design/cls_step.sv -----
// Next-state logic of the bus sequencer: one clock tick of the phase machine.
// Depends on cls_pkg for the state, pin and configuration types.
module cls_step
    import cls_pkg::*;
(
    input  cls_state_t cur,
    input  cls_cfg_t   cfg,
    input  logic [1:0] opcode,
    input  logic [7:0] value,
    input  logic [6:0] column,
    input  logic [1:0] row,
    input  logic [7:0] bus_in,
    output cls_state_t nxt
);

    // Enters a phase, skipping zero-length waits, and loads its pins and timer.
    function automatic cls_state_t enter_phase(cls_state_t s, logic [2:0] p, cls_cfg_t c);
        cls_state_t  n;
        logic [2:0]  q;
        logic [7:0]  ulen;
        logic [13:0] pre_units;
        logic [13:0] post_units;
        n = s;
        q = p;
        ulen = (c.quarter_ticks == 8'd0) ? 8'd1 : c.quarter_ticks;
        pre_units = {4'd0, c.cmd_pre_us, 2'b00};
        if (s.kind == OP_CMD)
            post_units = {c.cmd_post_us, 2'b00};
        else if (s.kind == OP_CHAR)
            post_units = {4'd0, c.data_post_us, 2'b00};
        else
            post_units = 14'd0;
        if (q == PH_PRE && pre_units == 14'd0)
            q = PH_WR_E;
        if (q == PH_POST && post_units == 14'd0)
            q = PH_IDLE;
        n.phase = q;
        case (q)
            PH_POLL:
            begin
                n.pins.e = 1'b1;
                n.pins.rs = 1'b0;
                n.pins.rw = 1'b1;
                n.pins.sel = 1'b1;
                n.pins.drive = 1'b0;
                n.units_left = 14'd2;
                n.tick_count = ulen;
            end
            PH_RELEASE:
            begin
                n.pins.e = 1'b0;
                n.pins.rs = 1'b0;
                n.pins.rw = 1'b1;
                n.pins.sel = 1'b1;
                n.pins.drive = 1'b1;
                n.units_left = 14'd1;
                n.tick_count = 8'd1;
            end
            PH_PRE:
            begin
                n.units_left = pre_units;
                n.tick_count = ulen;
            end
            PH_WR_E:
            begin
                n.pins.e = 1'b1;
                n.pins.rs = (s.kind == OP_CHAR);
                n.pins.rw = 1'b0;
                n.pins.sel = 1'b1;
                n.pins.drive = 1'b1;
                n.units_left = 14'd1;
                n.tick_count = ulen;
            end
            PH_WR_DATA:
            begin
                n.pins.data = s.latched;
                n.units_left = 14'd1;
                n.tick_count = ulen;
            end
            PH_WR_LOW:
            begin
                n.pins.e = 1'b0;
                n.units_left = 14'd1;
                n.tick_count = ulen;
            end
            PH_POST:
            begin
                n.units_left = post_units;
                n.tick_count = ulen;
            end
            default:
            begin
                n.phase = PH_IDLE;
                n.units_left = 14'd0;
                n.tick_count = 8'd0;
            end
        endcase
        return n;
    endfunction

    logic [7:0]  ulen;
    logic [7:0]  tick_dec;
    logic [13:0] units_dec;
    logic [7:0]  addr;
    cls_state_t  base;

    always_comb
    begin
        ulen = (cfg.quarter_ticks == 8'd0) ? 8'd1 : cfg.quarter_ticks;
        tick_dec = (cur.tick_count != 8'd0) ? cur.tick_count - 8'd1 : 8'd0;
        units_dec = (cur.units_left != 14'd0) ? cur.units_left - 14'd1 : 14'd0;
        addr = {1'b0, column} - 8'd1 + ((row != FIRST_ROW) ? ROW2_OFFSET : 8'd0);
        base = cur;
        nxt = cur;
        if (cur.phase == PH_IDLE)
        begin
            if (opcode != OP_TICK)
            begin
                base.kind = opcode;
                if (opcode == OP_CURSOR)
                begin
                    base.latched = CURSOR_CMD | addr;
                    nxt = enter_phase(base, PH_WR_E, cfg);
                end
                else
                begin
                    base.latched = value;
                    nxt = enter_phase(base, PH_POLL, cfg);
                end
            end
        end
        else if (tick_dec != 8'd0)
        begin
            nxt.tick_count = tick_dec;
        end
        else if (units_dec != 14'd0)
        begin
            nxt.tick_count = ulen;
            nxt.units_left = units_dec;
        end
        else
        begin
            case (cur.phase)
                PH_POLL:
                begin
                    base.status = bus_in;
                    nxt = enter_phase(base, PH_RELEASE, cfg);
                end
                PH_RELEASE:
                begin
                    if (cur.status[7])
                        nxt = enter_phase(base, PH_POLL, cfg);
                    else if (cur.kind == OP_CMD)
                        nxt = enter_phase(base, PH_PRE, cfg);
                    else
                        nxt = enter_phase(base, PH_WR_E, cfg);
                end
                PH_PRE:     nxt = enter_phase(base, PH_WR_E, cfg);
                PH_WR_E:    nxt = enter_phase(base, PH_WR_DATA, cfg);
                PH_WR_DATA: nxt = enter_phase(base, PH_WR_LOW, cfg);
                PH_WR_LOW:
                    nxt = enter_phase(base, (cur.kind == OP_CURSOR) ? PH_IDLE : PH_POST, cfg);
                default:    nxt = enter_phase(base, PH_IDLE, cfg);
            endcase
        end
    end

endmodule

// ----- design/char_lcd_bus_sequencer.sv -----
// Top level of the character LCD bus sequencer: configuration registers, input stage,
// sequencer state and result register. Depends on cls_pkg, cls_if.sv and cls_step.
//
//   channel  direction  beat contents
//   cmd      in         opcode, value, column, row, bus_in (one clock tick of the sequencer)
//   rsp      out        pin levels, busy flag and last status byte after that tick
//   cfg_*    in         register write, no handshake
//
// One beat is accepted per cycle while rsp is not stalled; it is held in the input stage,
// then cls_step computes its result combinationally, which is registered and offered on rsp.
// Reset returns to idle with all pins low except data drive, and restores register defaults.
// A stall on rsp holds the stage and the state; cmd.ready drops only while both are full.
module char_lcd_bus_sequencer
    import cls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cls_cmd_if.sink               cmd,
    cls_rsp_if.source             rsp
);

    cls_cfg_t   cfg_reg;
    cls_cfg_t   cfg_next;
    cls_state_t state_reg;
    cls_state_t state_next;

    logic       stage_valid_reg;
    logic [1:0] stage_opcode_reg;
    logic [7:0] stage_value_reg;
    logic [6:0] stage_column_reg;
    logic [1:0] stage_row_reg;
    logic [7:0] stage_bus_reg;

    logic       res_valid_reg;
    logic       res_valid_next;
    cls_pins_t  res_pins_reg;
    logic       res_busy_reg;
    logic [7:0] res_status_reg;

    logic       advance;
    logic       take;

    assign advance = stage_valid_reg && (!res_valid_reg || rsp.ready);
    assign cmd.ready = !stage_valid_reg || advance;
    assign take = cmd.valid && cmd.ready;

    cls_step u_step (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .opcode (stage_opcode_reg),
        .value  (stage_value_reg),
        .column (stage_column_reg),
        .row    (stage_row_reg),
        .bus_in (stage_bus_reg),
        .nxt    (state_next)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_QUARTER_TICKS: cfg_next.quarter_ticks = cfg_data[7:0];
                REG_CMD_PRE_US:    cfg_next.cmd_pre_us = cfg_data[7:0];
                REG_CMD_POST_US:   cfg_next.cmd_post_us = cfg_data[11:0];
                REG_DATA_POST_US:  cfg_next.data_post_us = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
        if (advance)
            res_valid_next = 1'b1;
        else if (rsp.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quarter_ticks <= RST_QUARTER_TICKS;
            cfg_reg.cmd_pre_us <= RST_CMD_PRE_US;
            cfg_reg.cmd_post_us <= RST_CMD_POST_US;
            cfg_reg.data_post_us <= RST_DATA_POST_US;
            state_reg.phase <= PH_IDLE;
            state_reg.tick_count <= 8'd0;
            state_reg.units_left <= 14'd0;
            state_reg.latched <= 8'd0;
            state_reg.kind <= OP_TICK;
            state_reg.pins <= '{e: 1'b0, rs: 1'b0, rw: 1'b0, sel: 1'b0,
                                data: 8'd0, drive: 1'b1};
            state_reg.status <= 8'd0;
            stage_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (advance)
                state_reg <= state_next;
            if (take)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_opcode_reg <= cmd.opcode;
            stage_value_reg <= cmd.value;
            stage_column_reg <= cmd.column;
            stage_row_reg <= cmd.row;
            stage_bus_reg <= cmd.bus_in;
        end
        if (advance)
        begin
            res_pins_reg <= state_next.pins;
            res_busy_reg <= (state_next.phase != PH_IDLE);
            res_status_reg <= state_next.status;
        end
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.enable_pin = res_pins_reg.e;
    assign rsp.reg_select_pin = res_pins_reg.rs;
    assign rsp.read_write_pin = res_pins_reg.rw;
    assign rsp.select_pin = res_pins_reg.sel;
    assign rsp.data_out = res_pins_reg.data;
    assign rsp.drive_data = res_pins_reg.drive;
    assign rsp.busy_res = res_busy_reg;
    assign rsp.status_byte = res_status_reg;

    // The timers are cleared whenever the sequencer rests in idle.
    a_idle_timers_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE) |-> (state_reg.tick_count == 8'd0 &&
                                          state_reg.units_left == 14'd0))
        else $error("idle phase with a running timer");

    // Every active phase holds at least one tick and one unit.
    a_active_timers_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != PH_IDLE) |-> (state_reg.tick_count != 8'd0 &&
                                          state_reg.units_left != 14'd0))
        else $error("active phase with an empty timer");

    // The data pins are released only during a status poll.
    a_undriven_only_in_poll: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.pins.drive |-> (state_reg.phase == PH_POLL))
        else $error("data pins released outside a poll");

    // The state moves only when a beat passes into the result register.
    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without a beat");

endmodule

// ----- bench/char_lcd_bus_sequencer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for char_lcd_bus_sequencer: feeds clock-tick beats carrying display
// requests, predicts the pin levels of every tick and compares them field by field.
// Depends on cls_pkg (design/cls_pkg.sv) and the channel interfaces in design/cls_if.sv.
module char_lcd_bus_sequencer_tb;
    import cls_pkg::*;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] value;
        logic [6:0] column;
        logic [1:0] row;
        logic [7:0] bus_in;
    } lcd_beat_t;

    typedef struct packed {
        logic       enable_pin;
        logic       reg_select_pin;
        logic       read_write_pin;
        logic       select_pin;
        logic [7:0] data_out;
        logic       drive_data;
        logic       busy_res;
        logic [7:0] status_byte;
    } lcd_pins_t;

    typedef enum logic {STEP_BEAT, STEP_REG} step_kind_e;

    typedef struct packed {
        step_kind_e kind;
        lcd_beat_t  beat;
        logic       typed;
        lcd_pins_t  want;
        logic [1:0] reg_idx;
        logic [11:0] reg_data;
    } dir_step_t;

    localparam lcd_pins_t PINS_AFTER_RESET =
        '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00};
    localparam lcd_pins_t PINS_CURSOR_START =
        '{1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1, 8'h00};
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 4;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cls_cmd_if cmd_ch ();
    cls_rsp_if rsp_ch ();

    char_lcd_bus_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    always #10 clk = ~clk;

    cls_cfg_t    seq_cfg;
    cls_state_t  seq;
    lcd_pins_t   pins_due [$];
    dir_step_t   dir_steps [$];

    int errors = 0;
    int beats_sent = 0;
    int requests_started = 0;
    int repolls = 0;
    int pins_checked = 0;
    int burst_left = 0;
    int steady_left = 0;
    int hold_left = 0;
    int rx_cyc = 0;
    int stuck_cycles = 0;
    bit sender_gaps = 1'b1;
    bit hold_req = 1'b0;

    function automatic logic [7:0] unit_cycles();
        return (seq_cfg.quarter_ticks == 8'd0) ? 8'd1 : seq_cfg.quarter_ticks;
    endfunction

    task automatic set_ctrl_pins(input logic e, input logic rs, input logic rw,
                                 input logic drive);
        seq.pins.e     = e;
        seq.pins.rs    = rs;
        seq.pins.rw    = rw;
        seq.pins.sel   = 1'b1;
        seq.pins.drive = drive;
    endtask

    task automatic start_count(input logic [13:0] units, input logic [7:0] ticks);
        seq.units_left = units;
        seq.tick_count = ticks;
    endtask

    task automatic enter_phase(input logic [2:0] target);
        logic [2:0]  ph;
        logic [13:0] units;
        bit          again;
        ph = target;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            seq.phase = ph;
            case (ph)
                PH_POLL:
                begin
                    set_ctrl_pins(1'b1, 1'b0, 1'b1, 1'b0);
                    start_count(14'd2, unit_cycles());
                end
                PH_RELEASE:
                begin
                    set_ctrl_pins(1'b0, 1'b0, 1'b1, 1'b1);
                    start_count(14'd1, 8'd1);
                end
                PH_PRE:
                begin
                    units = {4'd0, seq_cfg.cmd_pre_us, 2'b00};
                    if (units == 14'd0)
                    begin
                        ph = PH_WR_E;
                        again = 1'b1;
                    end
                    else
                        start_count(units, unit_cycles());
                end
                PH_WR_E:
                begin
                    set_ctrl_pins(1'b1, seq.kind == OP_CHAR, 1'b0, 1'b1);
                    start_count(14'd1, unit_cycles());
                end
                PH_WR_DATA:
                begin
                    seq.pins.data = seq.latched;
                    start_count(14'd1, unit_cycles());
                end
                PH_WR_LOW:
                begin
                    seq.pins.e = 1'b0;
                    start_count(14'd1, unit_cycles());
                end
                PH_POST:
                begin
                    if (seq.kind == OP_CMD)
                        units = {seq_cfg.cmd_post_us, 2'b00};
                    else if (seq.kind == OP_CHAR)
                        units = {4'd0, seq_cfg.data_post_us, 2'b00};
                    else
                        units = 14'd0;
                    if (units == 14'd0)
                    begin
                        ph = PH_IDLE;
                        again = 1'b1;
                    end
                    else
                        start_count(units, unit_cycles());
                end
                default:
                begin
                    seq.phase = PH_IDLE;
                    seq.tick_count = 8'd0;
                    seq.units_left = 14'd0;
                end
            endcase
        end
    endtask

    task automatic finish_phase(input logic [7:0] bus);
        case (seq.phase)
            PH_POLL:
            begin
                seq.status = bus;
                enter_phase(PH_RELEASE);
            end
            PH_RELEASE:
            begin
                if (seq.status[7])
                begin
                    repolls++;
                    enter_phase(PH_POLL);
                end
                else if (seq.kind == OP_CMD)
                    enter_phase(PH_PRE);
                else
                    enter_phase(PH_WR_E);
            end
            PH_PRE:     enter_phase(PH_WR_E);
            PH_WR_E:    enter_phase(PH_WR_DATA);
            PH_WR_DATA: enter_phase(PH_WR_LOW);
            PH_WR_LOW:  enter_phase(seq.kind == OP_CURSOR ? PH_IDLE : PH_POST);
            default:    enter_phase(PH_IDLE);
        endcase
    endtask

    // One tick of the sequencer: start a request when idle, else run the unit timer.
    task automatic advance_sequencer(input lcd_beat_t b, output lcd_pins_t pins);
        logic [7:0] addr;
        if (seq.phase == PH_IDLE)
        begin
            if (b.opcode != OP_TICK)
            begin
                requests_started++;
                seq.kind = b.opcode;
                if (b.opcode == OP_CURSOR)
                begin
                    addr = {1'b0, b.column} - 8'd1;
                    if (b.row != FIRST_ROW)
                        addr = addr + ROW2_OFFSET;
                    seq.latched = CURSOR_CMD | addr;
                    enter_phase(PH_WR_E);
                end
                else
                begin
                    seq.latched = b.value;
                    enter_phase(PH_POLL);
                end
            end
        end
        else
        begin
            if (seq.tick_count != 8'd0)
                seq.tick_count = seq.tick_count - 8'd1;
            if (seq.tick_count == 8'd0)
            begin
                if (seq.units_left != 14'd0)
                    seq.units_left = seq.units_left - 14'd1;
                if (seq.units_left == 14'd0)
                    finish_phase(b.bus_in);
                else
                    seq.tick_count = unit_cycles();
            end
        end
        pins = '{seq.pins.e, seq.pins.rs, seq.pins.rw, seq.pins.sel, seq.pins.data,
                 seq.pins.drive, seq.phase != PH_IDLE, seq.status};
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic lcd_beat_t filler(input logic [1:0] op);
        lcd_beat_t b;
        b.opcode = op;
        b.value  = 8'($urandom);
        b.column = 7'($urandom_range(0, 127));
        b.row    = 2'($urandom_range(0, 3));
        b.bus_in = 8'($urandom);
        if ($urandom_range(0, 2) != 0)
            b.bus_in[7] = 1'b0;
        return b;
    endfunction

    function automatic lcd_beat_t request_beat();
        lcd_beat_t b;
        b = filler(2'($urandom_range(1, 3)));
        if ($urandom_range(0, 9) != 0)
        begin
            b.column = 7'($urandom_range(1, 64));
            b.row    = 2'($urandom_range(1, 2));
        end
        return b;
    endfunction

    function automatic dir_step_t beat_row(input logic [1:0] op, input logic [7:0] value,
                                           input logic [6:0] column, input logic [1:0] row,
                                           input logic [7:0] bus);
        dir_step_t s;
        s = '0;
        s.kind = STEP_BEAT;
        s.beat = '{op, value, column, row, bus};
        return s;
    endfunction

    function automatic dir_step_t reg_row(input logic [1:0] idx, input logic [11:0] data);
        dir_step_t s;
        s = '0;
        s.kind = STEP_REG;
        s.reg_idx = idx;
        s.reg_data = data;
        return s;
    endfunction

    task automatic offer(input lcd_beat_t b);
        lcd_pins_t want;
        int        gap;
        if (steady_left > 0)
            steady_left--;
        else if (burst_left == 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        else
            burst_left--;
        cmd_ch.valid  <= 1'b1;
        cmd_ch.opcode <= b.opcode;
        cmd_ch.value  <= b.value;
        cmd_ch.column <= b.column;
        cmd_ch.row    <= b.row;
        cmd_ch.bus_in <= b.bus_in;
        do @(posedge clk); while (!cmd_ch.ready);
        advance_sequencer(b, want);
        pins_due.push_back(want);
        beats_sent++;
    endtask

    task automatic run_to_idle();
        while (seq.phase != PH_IDLE)
            offer(filler(2'($urandom_range(0, 3))));
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_QUARTER_TICKS: seq_cfg.quarter_ticks = data[7:0];
            REG_CMD_PRE_US:    seq_cfg.cmd_pre_us    = data[7:0];
            REG_CMD_POST_US:   seq_cfg.cmd_post_us   = data;
            REG_DATA_POST_US:  seq_cfg.data_post_us  = data[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [11:0] qt, input logic [11:0] pre,
                             input logic [11:0] cpost, input logic [11:0] dpost);
        settle();
        write_reg(REG_QUARTER_TICKS, qt);
        write_reg(REG_CMD_PRE_US, pre);
        write_reg(REG_CMD_POST_US, cpost);
        write_reg(REG_DATA_POST_US, dpost);
    endtask

    task automatic run_random(input int count, input bit gaps);
        int stop_at;
        stop_at = beats_sent + count;
        sender_gaps = gaps;
        while (beats_sent < stop_at)
        begin
            if (seq.phase != PH_IDLE)
                offer(filler(2'($urandom_range(0, 3))));
            else if ($urandom_range(0, 4) != 0)
                offer(request_beat());
            else
                offer(filler(OP_TICK));
        end
        run_to_idle();
    endtask

    // Starts one request and follows it with the given number of tick beats.
    task automatic run_open(input logic [1:0] op, input int count);
        lcd_beat_t b;
        b = request_beat();
        b.opcode = op;
        offer(b);
        repeat (count) offer(filler(OP_TICK));
    endtask

    always @(posedge clk)
    begin : pin_sink
        lcd_pins_t got;
        lcd_pins_t want;
        rx_cyc++;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.enable_pin, rsp_ch.reg_select_pin, rsp_ch.read_write_pin,
                    rsp_ch.select_pin, rsp_ch.data_out, rsp_ch.drive_data,
                    rsp_ch.busy_res, rsp_ch.status_byte};
            if (pins_due.size() == 0)
            begin
                $error("Pin beat arrived with nothing pending.");
                errors++;
            end
            else
            begin
                want = pins_due.pop_front();
                pins_checked++;
                check_field("enable_pin", 8'(want.enable_pin), 8'(got.enable_pin));
                check_field("reg_select_pin", 8'(want.reg_select_pin),
                            8'(got.reg_select_pin));
                check_field("read_write_pin", 8'(want.read_write_pin),
                            8'(got.read_write_pin));
                check_field("select_pin", 8'(want.select_pin), 8'(got.select_pin));
                check_field("data_out", want.data_out, got.data_out);
                check_field("drive_data", 8'(want.drive_data), 8'(got.drive_data));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("status_byte", want.status_byte, got.status_byte);
            end
        end
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_cyc[9:8])
                2'd0:    rsp_ch.ready <= 1'b1;
                2'd1:    rsp_ch.ready <= (rx_cyc[2:0] != 3'd5) && (rx_cyc[2:0] != 3'd6);
                2'd2:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ch.ready <= rx_cyc[3] | rx_cyc[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_step_t st;
        bit        quiet;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_QUARTER_TICKS;
        cfg_data      = '0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.opcode = OP_TICK;
        cmd_ch.value  = 8'd0;
        cmd_ch.column = 7'd0;
        cmd_ch.row    = 2'd0;
        cmd_ch.bus_in = 8'd0;
        rsp_ch.ready  = 1'b0;
        seq_cfg = '{RST_QUARTER_TICKS, RST_CMD_PRE_US, RST_CMD_POST_US, RST_DATA_POST_US};
        seq = '0;
        seq.pins.drive = 1'b1;
        quiet = 1'b1;

        st = beat_row(OP_TICK, 8'hFF, 7'd127, 2'd3, 8'hFF);
        st.typed = 1'b1;
        st.want = PINS_AFTER_RESET;
        dir_steps.push_back(st);
        st = beat_row(OP_TICK, 8'h00, 7'd0, 2'd0, 8'h00);
        st.typed = 1'b1;
        st.want = PINS_AFTER_RESET;
        dir_steps.push_back(st);
        dir_steps.push_back(reg_row(REG_QUARTER_TICKS, 12'h001));
        dir_steps.push_back(reg_row(REG_CMD_POST_US, 12'h002));
        dir_steps.push_back(reg_row(REG_DATA_POST_US, 12'h001));
        st = beat_row(OP_CURSOR, 8'h00, 7'd1, 2'd1, 8'h00);
        st.typed = 1'b1;
        st.want = PINS_CURSOR_START;
        dir_steps.push_back(st);
        dir_steps.push_back(beat_row(OP_CMD, 8'h01, 7'd5, 2'd1, 8'h00));
        dir_steps.push_back(beat_row(OP_CHAR, 8'h41, 7'd5, 2'd1, 8'h00));
        dir_steps.push_back(reg_row(REG_QUARTER_TICKS, 12'hF00));
        dir_steps.push_back(reg_row(REG_CMD_PRE_US, 12'h000));
        dir_steps.push_back(reg_row(REG_CMD_POST_US, 12'h000));
        dir_steps.push_back(reg_row(REG_DATA_POST_US, 12'hF00));
        dir_steps.push_back(beat_row(OP_CMD, 8'h00, 7'd1, 2'd1, 8'h80));
        dir_steps.push_back(beat_row(OP_CMD, 8'hFF, 7'd1, 2'd1, 8'h7F));
        dir_steps.push_back(beat_row(OP_CHAR, 8'h00, 7'd1, 2'd1, 8'hFF));
        dir_steps.push_back(beat_row(OP_CHAR, 8'hFF, 7'd1, 2'd1, 8'h00));
        dir_steps.push_back(beat_row(OP_CURSOR, 8'h00, 7'd1, 2'd1, 8'h00));
        dir_steps.push_back(beat_row(OP_CURSOR, 8'hFF, 7'd64, 2'd2, 8'h00));
        dir_steps.push_back(beat_row(OP_CURSOR, 8'h00, 7'd64, 2'd1, 8'h00));
        dir_steps.push_back(beat_row(OP_CURSOR, 8'h00, 7'd1, 2'd2, 8'h00));
        dir_steps.push_back(beat_row(OP_CURSOR, 8'h00, 7'd0, 2'd1, 8'h00));
        dir_steps.push_back(beat_row(OP_CURSOR, 8'h00, 7'd127, 2'd0, 8'h00));
        dir_steps.push_back(beat_row(OP_CURSOR, 8'h00, 7'd127, 2'd3, 8'h00));
        dir_steps.push_back(beat_row(OP_CURSOR, 8'h00, 7'd0, 2'd3, 8'h00));
        dir_steps.push_back(beat_row(OP_TICK, 8'h5A, 7'd33, 2'd2, 8'hA5));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_steps[i])
        begin
            st = dir_steps[i];
            if (st.kind == STEP_REG)
            begin
                if (!quiet)
                begin
                    settle();
                    quiet = 1'b1;
                end
                write_reg(st.reg_idx, st.reg_data);
            end
            else
            begin
                quiet = 1'b0;
                offer(st.beat);
                if (st.typed)
                    pins_due[pins_due.size() - 1] = st.want;
                run_to_idle();
            end
        end

        // The receiver holds off while the sender keeps offering, so the block backs up.
        write_all(12'h001, 12'($urandom_range(0, 2)), 12'($urandom_range(0, 3)),
                  12'($urandom_range(0, 3)));
        hold_req = 1'b1;
        steady_left = 40;
        run_random(90, 1'b1);
        write_all(12'($urandom_range(2, 3)), 12'($urandom_range(0, 2)),
                  12'($urandom_range(0, 3)), 12'($urandom_range(0, 3)));
        run_random(90, 1'b0);
        write_all(12'h000, 12'($urandom_range(0, 2)), 12'($urandom_range(0, 3)),
                  12'($urandom_range(0, 3)));
        run_random(90, 1'b1);

        write_all(12'h001, 12'h000, 12'hFFF, 12'hFFF);
        run_open(OP_CMD, 40);

        settle();
        $display("Sent %0d tick beats: %0d display requests started, %0d busy re-polls.",
                 beats_sent, requests_started, repolls);
        $display("Checked %0d pin beats across zero, short and widest wait settings.",
                 pins_checked);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
